@@ src/ecint_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ecint_pkg
// Types, widths and helpers shared by the elevation color interpolator.
// ----------------------------------------------------------------------------
package ecint_pkg;

  localparam int ALPHA_FRAC_BITS = 16;
  localparam int GAMMA_CHANNELS  = 3;

  localparam int ELEV_W     = 16;
  localparam int DEN_W      = 16;
  localparam int ALPHA_W    = ALPHA_FRAC_BITS + 1;
  localparam int LANE_W     = 16;
  localparam int PROD_W     = ALPHA_W + LANE_W;
  localparam int TEMP_W     = 15;
  localparam int BRIGHT_W   = 15;
  localparam int GAMMA_W    = 16;
  localparam int GAMMA_OUT  = 3;
  localparam int PROG_W     = 17;
  localparam int PROG_FRAC  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam int LANE_TEMP   = 0;
  localparam int LANE_BRIGHT = 1;
  localparam int LANE_GAMMA0 = 2;
  localparam int NUM_LANES   = LANE_GAMMA0 + GAMMA_OUT;

  localparam int PROG_SH_R = (ALPHA_FRAC_BITS >= PROG_FRAC) ? ALPHA_FRAC_BITS - PROG_FRAC : 0;
  localparam int PROG_SH_L = (ALPHA_FRAC_BITS < PROG_FRAC) ? PROG_FRAC - ALPHA_FRAC_BITS : 0;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = {1'b1, {ALPHA_FRAC_BITS{1'b0}}};
  localparam logic [PROG_W-1:0]  PROG_ONE  = {1'b1, {PROG_FRAC{1'b0}}};

  typedef enum logic [1:0] {
    PHASE_NIGHT = 2'd0,
    PHASE_TRANS = 2'd1,
    PHASE_DAY   = 2'd2
  } sun_phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_ELEV     = 3'd0,
    REG_HIGH_ELEV    = 3'd1,
    REG_DAY_TEMP     = 3'd2,
    REG_NIGHT_TEMP   = 3'd3,
    REG_DAY_BRIGHT   = 3'd4,
    REG_NIGHT_BRIGHT = 3'd5,
    REG_DAY_GAMMA    = 3'd6,
    REG_NIGHT_GAMMA  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    sun_phase_t                 period;
    logic [DEN_W-1:0]           rem;
    logic [DEN_W-1:0]           den;
    logic [ALPHA_FRAC_BITS-1:0] quo;
  } div_tok_t;

  typedef logic [NUM_LANES-1:0][LANE_W-1:0] lane_vec_t;

  typedef struct packed {
    lane_vec_t day;
    lane_vec_t night;
  } blend_cfg_t;

  // one restoring step: one quotient bit
  function automatic div_tok_t div_step(div_tok_t t);
    logic [DEN_W:0] r2;
    logic [DEN_W:0] d2;
    div_tok_t       o;
    o  = t;
    r2 = {t.rem, 1'b0};
    d2 = {1'b0, t.den};
    if (r2 >= d2) begin
      o.rem = DEN_W'(r2 - d2);
      o.quo = {t.quo[ALPHA_FRAC_BITS-2:0], 1'b1};
    end else begin
      o.rem = r2[DEN_W-1:0];
      o.quo = {t.quo[ALPHA_FRAC_BITS-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage
`default_nettype wire

@@ src/ecint_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ecint_in_if
// Elevation sample channel: valid, ready and one signed Q7.8 elevation.
// ----------------------------------------------------------------------------
interface ecint_in_if import ecint_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [ELEV_W-1:0] elevation;

  modport source (output valid, output elevation, input ready);
  modport sink   (input valid, input elevation, output ready);

endinterface
`default_nettype wire

@@ src/ecint_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ecint_out_if
// Result channel: period, progress and the blended display settings.
// ----------------------------------------------------------------------------
interface ecint_out_if import ecint_pkg::*; ();

  logic                valid;
  logic                ready;
  sun_phase_t          period;
  logic [PROG_W-1:0]   progress;
  logic [TEMP_W-1:0]   temperature_out;
  logic [BRIGHT_W-1:0] brightness_out;
  logic [GAMMA_W-1:0]  gamma_red;
  logic [GAMMA_W-1:0]  gamma_green;
  logic [GAMMA_W-1:0]  gamma_blue;

  modport source (output valid, output period, output progress, output temperature_out,
                  output brightness_out, output gamma_red, output gamma_green,
                  output gamma_blue, input ready);
  modport sink   (input valid, input period, input progress, input temperature_out,
                  input brightness_out, input gamma_red, input gamma_green,
                  input gamma_blue, output ready);

endinterface
`default_nettype wire

@@ src/ecint_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ecint_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ecint_div import ecint_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire div_tok_t in_tok,
  output logic          out_valid,
  input  wire logic     out_ready,
  output div_tok_t      out_tok
);

  localparam int NSTG = ALPHA_FRAC_BITS;

  logic [NSTG-1:0] vld_r;
  div_tok_t        tok_r [NSTG];
  logic [NSTG:0]   chain_v;
  logic [NSTG:0]   chain_rdy;
  div_tok_t        chain_t [NSTG+1];

  assign chain_v[0]      = in_valid;
  assign chain_t[0]      = in_tok;
  assign chain_rdy[NSTG] = out_ready;

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    assign chain_v[k+1]  = vld_r[k];
    assign chain_t[k+1]  = tok_r[k];
    assign chain_rdy[k]  = !vld_r[k] || chain_rdy[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (chain_rdy[k]) begin
          vld_r[k] <= chain_v[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTG; k++) begin
      if (chain_rdy[k] && chain_v[k]) begin
        tok_r[k] <= div_step(chain_t[k]);
      end
    end
  end

  assign in_ready  = chain_rdy[0];
  assign out_valid = chain_v[NSTG];
  assign out_tok   = chain_t[NSTG];

endmodule
`default_nettype wire

@@ src/ecint_blend.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ecint_blend
// Alpha select and lane products, then night plus scaled difference.
// ----------------------------------------------------------------------------
module ecint_blend import ecint_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire div_tok_t   in_tok,
  input  wire blend_cfg_t cfg,
  ecint_out_if.source     out_ch
);

  logic                             vm_r;
  sun_phase_t                       period_m_r;
  logic [ALPHA_W-1:0]               alpha_m_r;
  logic [NUM_LANES-1:0][PROD_W-1:0] prod_m_r;
  logic                             rdy_m;
  logic                             rdy_f;
  logic [ALPHA_W-1:0]               alpha_nxt;
  logic [NUM_LANES-1:0][PROD_W-1:0] prod_nxt;

  logic                             vf_r;
  sun_phase_t                       period_r;
  logic [PROG_W-1:0]                progress_r;
  lane_vec_t                        res_r;
  lane_vec_t                        res_nxt;
  logic [PROG_W-1:0]                progress_nxt;

  assign rdy_f    = !vf_r || out_ch.ready;
  assign rdy_m    = !vm_r || rdy_f;
  assign in_ready = rdy_m;

  always_comb begin
    case (in_tok.period)
      PHASE_NIGHT: alpha_nxt = '0;
      PHASE_TRANS: alpha_nxt = {1'b0, in_tok.quo};
      default:     alpha_nxt = ALPHA_ONE;
    endcase
  end

  always_comb begin
    logic [LANE_W-1:0] d;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (cfg.day[i] >= cfg.night[i]) begin
        d = cfg.day[i] - cfg.night[i];
      end else begin
        d = cfg.night[i] - cfg.day[i];
      end
      prod_nxt[i] = PROD_W'(alpha_nxt) * PROD_W'(d);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (rdy_m) begin
      vm_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_m && in_valid) begin
      period_m_r <= in_tok.period;
      alpha_m_r  <= alpha_nxt;
      prod_m_r   <= prod_nxt;
    end
  end

  always_comb begin
    logic [LANE_W-1:0] step;
    for (int i = 0; i < NUM_LANES; i++) begin
      step = prod_m_r[i][ALPHA_FRAC_BITS +: LANE_W];
      if (i >= LANE_GAMMA0 + GAMMA_CHANNELS) begin
        res_nxt[i] = '0;
      end else if (cfg.day[i] >= cfg.night[i]) begin
        res_nxt[i] = cfg.night[i] + step;
      end else begin
        res_nxt[i] = cfg.night[i] - step;
      end
    end
  end

  assign progress_nxt = PROG_W'(({{PROG_W{1'b0}}, alpha_m_r} >> PROG_SH_R) << PROG_SH_L);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (rdy_f) begin
      vf_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_f && vm_r) begin
      period_r   <= period_m_r;
      progress_r <= progress_nxt;
      res_r      <= res_nxt;
    end
  end

  assign out_ch.valid           = vf_r;
  assign out_ch.period          = period_r;
  assign out_ch.progress        = progress_r;
  assign out_ch.temperature_out = res_r[LANE_TEMP][TEMP_W-1:0];
  assign out_ch.brightness_out  = res_r[LANE_BRIGHT][BRIGHT_W-1:0];
  assign out_ch.gamma_red       = res_r[LANE_GAMMA0];
  assign out_ch.gamma_green     = res_r[LANE_GAMMA0+1];
  assign out_ch.gamma_blue      = res_r[LANE_GAMMA0+2];

endmodule
`default_nettype wire

@@ src/elevation_color_interpolator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// elevation_color_interpolator_top
// Classifies a solar elevation sample and blends night and day settings.
//
// in_ch carries one signed Q7.8 elevation per beat; out_ch returns one result
// beat per sample: period, progress in Q1.16, temperature, brightness and the
// three gamma values. The cfg port writes the threshold and setting registers
// by index; write only while no sample is in flight.
// From accepted input beat to valid result a beat passes one classify stage,
// one divider stage per quotient bit, one product stage and one sum stage. A
// new beat is taken every cycle unless out_ch stalls and every stage is full.
// Each stage holds its own valid bit, so when out_ch stalls the stages fill
// up behind the held result and in_ch.ready drops only once every stage is
// full; nothing is dropped or repeated.
// Reset loads the register defaults and empties the pipeline.
// ----------------------------------------------------------------------------
module elevation_color_interpolator_top import ecint_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ecint_in_if.sink                   in_ch,
  ecint_out_if.source                out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic signed [ELEV_W-1:0]        low_elev_r;
  logic signed [ELEV_W-1:0]        high_elev_r;
  logic [TEMP_W-1:0]               day_temp_r;
  logic [TEMP_W-1:0]               night_temp_r;
  logic [BRIGHT_W-1:0]             day_bright_r;
  logic [BRIGHT_W-1:0]             night_bright_r;
  logic [GAMMA_OUT*GAMMA_W-1:0]    day_gamma_r;
  logic [GAMMA_OUT*GAMMA_W-1:0]    night_gamma_r;

  logic                            s0_vld_r;
  div_tok_t                        s0_tok_r;
  div_tok_t                        s0_tok_nxt;
  logic                            s0_rdy;
  logic                            div_in_ready;
  logic                            div_out_valid;
  logic                            blend_in_ready;
  div_tok_t                        div_out_tok;
  blend_cfg_t                      bcfg;
  logic [DEN_W-1:0]                num_full;
  logic [DEN_W-1:0]                den_full;
  logic signed [ELEV_W-1:0]        elev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_elev_r     <= -16'sd1536;
      high_elev_r    <= 16'sd768;
      day_temp_r     <= 15'd6500;
      night_temp_r   <= 15'd4500;
      day_bright_r   <= 15'd16384;
      night_bright_r <= 15'd16384;
      day_gamma_r    <= 48'h1000_1000_1000;
      night_gamma_r  <= 48'h1000_1000_1000;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LOW_ELEV:     low_elev_r     <= cfg_data[ELEV_W-1:0];
        REG_HIGH_ELEV:    high_elev_r    <= cfg_data[ELEV_W-1:0];
        REG_DAY_TEMP:     day_temp_r     <= cfg_data[TEMP_W-1:0];
        REG_NIGHT_TEMP:   night_temp_r   <= cfg_data[TEMP_W-1:0];
        REG_DAY_BRIGHT:   day_bright_r   <= cfg_data[BRIGHT_W-1:0];
        REG_NIGHT_BRIGHT: night_bright_r <= cfg_data[BRIGHT_W-1:0];
        REG_DAY_GAMMA:    day_gamma_r    <= cfg_data[GAMMA_OUT*GAMMA_W-1:0];
        REG_NIGHT_GAMMA:  night_gamma_r  <= cfg_data[GAMMA_OUT*GAMMA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    bcfg.day[LANE_TEMP]     = LANE_W'(day_temp_r);
    bcfg.night[LANE_TEMP]   = LANE_W'(night_temp_r);
    bcfg.day[LANE_BRIGHT]   = LANE_W'(day_bright_r);
    bcfg.night[LANE_BRIGHT] = LANE_W'(night_bright_r);
    for (int i = 0; i < GAMMA_OUT; i++) begin
      bcfg.day[LANE_GAMMA0+i]   = day_gamma_r[i*GAMMA_W +: GAMMA_W];
      bcfg.night[LANE_GAMMA0+i] = night_gamma_r[i*GAMMA_W +: GAMMA_W];
    end
  end

  // classify stage
  assign elev     = in_ch.elevation;
  assign num_full = elev - low_elev_r;
  assign den_full = high_elev_r - low_elev_r;

  always_comb begin
    s0_tok_nxt.rem = num_full;
    s0_tok_nxt.den = den_full;
    s0_tok_nxt.quo = '0;
    if (elev < low_elev_r) begin
      s0_tok_nxt.period = PHASE_NIGHT;
    end else if (elev < high_elev_r) begin
      s0_tok_nxt.period = PHASE_TRANS;
    end else begin
      s0_tok_nxt.period = PHASE_DAY;
    end
  end

  assign s0_rdy      = !s0_vld_r || div_in_ready;
  assign in_ch.ready = s0_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (s0_rdy) begin
      s0_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_rdy && in_ch.valid) begin
      s0_tok_r <= s0_tok_nxt;
    end
  end

  ecint_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s0_vld_r),
    .in_ready  (div_in_ready),
    .in_tok    (s0_tok_r),
    .out_valid (div_out_valid),
    .out_ready (blend_in_ready),
    .out_tok   (div_out_tok)
  );

  ecint_blend u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (div_out_valid),
    .in_ready (blend_in_ready),
    .in_tok   (div_out_tok),
    .cfg      (bcfg),
    .out_ch   (out_ch)
  );

  a_night_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.period == PHASE_NIGHT |-> out_ch.progress == '0)
    else $error("night beat with nonzero progress");

  a_day_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.period == PHASE_DAY |-> out_ch.progress == PROG_ONE)
    else $error("day beat with progress other than one");

  a_trans_below_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.period == PHASE_TRANS |-> out_ch.progress < PROG_ONE)
    else $error("transition beat with progress at or above one");

  a_s0_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s0_vld_r && !div_in_ready |=> s0_vld_r && $stable(s0_tok_r))
    else $error("classify stage lost a beat while divider stalled");

endmodule
`default_nettype wire
